// ===== rtl/dqsr_pkg.sv =====
// shared types and constants for the deque with sum and descent series
// no dependencies

package dqsr_pkg;

  localparam int DEPTH_DEFAULT = 32;
  localparam int VALUE_W       = 32;
  localparam int REPORT_W      = 6;

  typedef enum logic [1:0] {
    OP_PUSH_BACK  = 2'd0,
    OP_POP_BACK   = 2'd1,
    OP_PUSH_FRONT = 2'd2,
    OP_POP_FRONT  = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    opcode_t                    opcode;
    logic signed [VALUE_W-1:0] value;
  } in_t;

  typedef struct packed {
    status_t                    status;
    logic [REPORT_W-1:0]        occupancy;
    logic signed [VALUE_W-1:0]  front_value;
    logic signed [VALUE_W-1:0]  back_value;
    logic signed [VALUE_W-1:0]  running_sum;
    logic [REPORT_W-1:0]        descent_series;
  } out_t;

endpackage

// ===== rtl/dqsr_store.sv =====
// entry memory: one write port, two registered read ports with write bypass
// depends on dqsr_pkg

module dqsr_store #(
  parameter int  DEPTH = dqsr_pkg::DEPTH_DEFAULT,
  localparam int PTR_W = $clog2(DEPTH)
) (
  input  logic                              clk,
  input  logic                              wr_en,
  input  logic [PTR_W-1:0]                  wr_addr,
  input  logic signed [dqsr_pkg::VALUE_W-1:0] wr_data,
  input  logic [PTR_W-1:0]                  rd_addr_a,
  input  logic [PTR_W-1:0]                  rd_addr_b,
  output logic signed [dqsr_pkg::VALUE_W-1:0] rd_data_a,
  output logic signed [dqsr_pkg::VALUE_W-1:0] rd_data_b
);

  logic signed [dqsr_pkg::VALUE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (wr_en && wr_addr == rd_addr_a) begin
      rd_data_a <= wr_data;
    end else begin
      rd_data_a <= mem[rd_addr_a];
    end
    if (wr_en && wr_addr == rd_addr_b) begin
      rd_data_b <= wr_data;
    end else begin
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule

// ===== rtl/deque_with_sum_and_runs.sv =====
// top level: bounded double-ended queue with running sum and descent series
// depends on dqsr_pkg and dqsr_store
//
// usage:
//   an item (cmd: opcode, value) is taken at a rising edge where start is high
//   and busy is low. busy is high only while and just after rst is applied,
//   so one item can be taken in every cycle.
//   each item gives exactly one result on the result port, marked by done
//   for a single cycle, once the item has passed the input register and then
//   the result register. items come out in order at one per cycle.
//   the end entries and their neighbors are held in registers; the neighbors
//   are refilled each cycle from the entry memory through its two read ports,
//   which sets the one-item-per-cycle rate.
//   a push into a full queue reports status full and changes nothing; a pop
//   from an empty queue reports status empty and changes nothing.
//   reset (synchronous, active high) empties the queue and clears sum and
//   series; stored entries are not cleared.
//   the receiver cannot hold results off: done is a strobe.

module deque_with_sum_and_runs #(
  parameter int DEPTH = dqsr_pkg::DEPTH_DEFAULT
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  dqsr_pkg::in_t   cmd,
  output logic            done,
  output dqsr_pkg::out_t  result
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
    return (p == '0) ? PTR_W'(DEPTH - 1) : p - 1'b1;
  endfunction

  dqsr_pkg::in_t  in_q;
  logic           in_valid;

  logic [PTR_W-1:0] head, head_next;
  logic [PTR_W-1:0] back_ptr, back_ptr_next;
  logic [CNT_W-1:0] count, count_next;
  logic [CNT_W-1:0] series, series_next;
  logic signed [dqsr_pkg::VALUE_W-1:0] sum, sum_next;
  logic signed [dqsr_pkg::VALUE_W-1:0] front_q, front_next;
  logic signed [dqsr_pkg::VALUE_W-1:0] back_q, back_next;
  logic signed [dqsr_pkg::VALUE_W-1:0] front2_q, back2_q;
  dqsr_pkg::status_t status_next;

  logic             wr_en;
  logic [PTR_W-1:0] wr_addr;
  logic [PTR_W-1:0] tail;
  logic             is_empty, is_full;

  assign tail     = ptr_dec(back_ptr);
  assign is_empty = (count == '0);
  assign is_full  = (count == CNT_W'(DEPTH));

  always_comb begin
    head_next     = head;
    back_ptr_next = back_ptr;
    count_next    = count;
    series_next   = series;
    sum_next      = sum;
    front_next    = front_q;
    back_next     = back_q;
    status_next   = dqsr_pkg::ST_OK;
    wr_en         = 1'b0;
    wr_addr       = back_ptr;
    if (in_valid) begin
      unique case (in_q.opcode)
        dqsr_pkg::OP_PUSH_BACK: begin
          if (is_full) begin
            status_next = dqsr_pkg::ST_FULL;
          end else begin
            wr_en         = 1'b1;
            wr_addr       = back_ptr;
            back_ptr_next = ptr_inc(back_ptr);
            count_next    = count + 1'b1;
            sum_next      = sum + in_q.value;
            back_next     = in_q.value;
            if (is_empty) begin
              series_next = CNT_W'(1);
              front_next  = in_q.value;
            end else if (back_q > in_q.value) begin
              series_next = series + 1'b1;
            end
          end
        end
        dqsr_pkg::OP_PUSH_FRONT: begin
          if (is_full) begin
            status_next = dqsr_pkg::ST_FULL;
          end else begin
            wr_en      = 1'b1;
            wr_addr    = ptr_dec(head);
            head_next  = ptr_dec(head);
            count_next = count + 1'b1;
            sum_next   = sum + in_q.value;
            front_next = in_q.value;
            if (is_empty) begin
              series_next = CNT_W'(1);
              back_next   = in_q.value;
            end else if (in_q.value > front_q) begin
              series_next = series + 1'b1;
            end
          end
        end
        dqsr_pkg::OP_POP_BACK: begin
          if (is_empty) begin
            status_next = dqsr_pkg::ST_EMPTY;
          end else begin
            back_ptr_next = tail;
            count_next    = count - 1'b1;
            sum_next      = sum - back_q;
            back_next     = back2_q;
            if (count == CNT_W'(1)) begin
              series_next = '0;
            end else if (back2_q > back_q) begin
              series_next = series - 1'b1;
            end
          end
        end
        dqsr_pkg::OP_POP_FRONT: begin
          if (is_empty) begin
            status_next = dqsr_pkg::ST_EMPTY;
          end else begin
            head_next  = ptr_inc(head);
            count_next = count - 1'b1;
            sum_next   = sum - front_q;
            front_next = front2_q;
            if (count == CNT_W'(1)) begin
              series_next = '0;
            end else if (front_q > front2_q) begin
              series_next = series - 1'b1;
            end
          end
        end
      endcase
    end
  end

  // neighbors of both ends, fetched for the state after this cycle
  dqsr_store #(
    .DEPTH (DEPTH)
  ) u_store (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (in_q.value),
    .rd_addr_a (ptr_inc(head_next)),
    .rd_addr_b (ptr_dec(ptr_dec(back_ptr_next))),
    .rd_data_a (front2_q),
    .rd_data_b (back2_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      in_valid <= 1'b0;
      done     <= 1'b0;
      head     <= '0;
      back_ptr <= '0;
      count    <= '0;
      sum      <= '0;
      series   <= '0;
    end else begin
      busy     <= 1'b0;
      in_valid <= start && !busy;
      done     <= in_valid;
      head     <= head_next;
      back_ptr <= back_ptr_next;
      count    <= count_next;
      sum      <= sum_next;
      series   <= series_next;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_q <= cmd;
    end
    front_q <= front_next;
    back_q  <= back_next;
    if (in_valid) begin
      result.status         <= status_next;
      result.occupancy      <= dqsr_pkg::REPORT_W'(count_next);
      result.front_value    <= (count_next == '0) ? '0 : front_next;
      result.back_value     <= (count_next == '0) ? '0 : back_next;
      result.running_sum    <= sum_next;
      result.descent_series <= dqsr_pkg::REPORT_W'(series_next);
    end
  end

endmodule

// ===== rtl/dqsr_checker.sv =====
// port-level checks for deque_with_sum_and_runs, attached by bind
// depends on dqsr_pkg

module dqsr_checker #(
  parameter int DEPTH = dqsr_pkg::DEPTH_DEFAULT
) (
  input logic           clk,
  input logic           rst,
  input logic           start,
  input logic           busy,
  input logic           done,
  input dqsr_pkg::out_t result
);

  logic accept;
  assign accept = start && !busy;

  // every item taken is followed by its result
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##2 done)
    else $error("item taken without a result two cycles later");

  // no result without an item
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, 2))
    else $error("result without a matching item");

  // an ignored pop leaves an empty queue with cleared figures
  a_empty_report: assert property (@(posedge clk) disable iff (rst)
    done && result.status == dqsr_pkg::ST_EMPTY |->
      result.occupancy == '0 && result.front_value == '0 &&
      result.back_value == '0 && result.running_sum == '0 &&
      result.descent_series == '0)
    else $error("empty pop reported a non-empty queue");

  // a dropped push only happens at full occupancy
  a_full_report: assert property (@(posedge clk) disable iff (rst)
    done && result.status == dqsr_pkg::ST_FULL |->
      result.occupancy == dqsr_pkg::REPORT_W'(DEPTH))
    else $error("dropped push below full occupancy");

endmodule

bind deque_with_sum_and_runs dqsr_checker #(
  .DEPTH (DEPTH)
) u_dqsr_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);
